// ===== rtl/tsbm_pkg.sv =====
// Shared types, command codes and waveform tables for the two-wire sensor bus master.
package tsbm_pkg;

  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_START      = 3'd1,
    CMD_CONN_RESET = 3'd2,
    CMD_WRITE      = 3'd3,
    CMD_READ       = 3'd4,
    CMD_WAIT       = 3'd5
  } cmd_t;

  localparam logic [4:0] IDLE_STEP       = 5'd31;
  localparam logic [4:0] START_PHASES    = 5'd7;
  localparam logic [4:0] RESET_PHASES    = 5'd26;
  localparam logic [4:0] BYTE_PHASES     = 5'd18;
  localparam logic [4:0] RESET_START_OFS = 5'd19;
  localparam logic [4:0] ACK_LOW_PHASE   = 5'd16;
  localparam logic [4:0] ACK_HIGH_PHASE  = 5'd17;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       data_in;
  } item_t;

  typedef struct packed {
    logic       sck_level;
    logic       data_drive;
    logic       data_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       no_ack;
    logic       rejected;
  } result_t;

  // Classified tick passed from front to back
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       data_in;
  } tick_t;

  function automatic cmd_t decode_op(input logic [2:0] op);
    cmd_t c;
    case (op)
      CMD_START:      c = CMD_START;
      CMD_CONN_RESET: c = CMD_CONN_RESET;
      CMD_WRITE:      c = CMD_WRITE;
      CMD_READ:       c = CMD_READ;
      CMD_WAIT:       c = CMD_WAIT;
      default:        c = CMD_NONE;
    endcase
    return c;
  endfunction

  // Start condition phases: returns {sck, level}
  function automatic logic [1:0] start_phase(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0:    r = 2'b01;
      3'd1:    r = 2'b11;
      3'd2:    r = 2'b10;
      3'd3:    r = 2'b00;
      3'd4:    r = 2'b10;
      3'd5:    r = 2'b11;
      default: r = 2'b01;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/tsbm_front.sv =====
// Front end: accepts tick beats, decodes the command and buffers them for the back end.
module tsbm_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  tsbm_pkg::item_t item,
  output logic           tick_valid,
  output tsbm_pkg::tick_t tick,
  input  logic           tick_take
);
  import tsbm_pkg::*;

  tick_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  tick_t      decoded;

  assign full       = (count == 2'd2);
  assign tick_valid = (count != 2'd0);
  assign tick       = q[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = tick_take && tick_valid;

  always_comb begin
    decoded.cmd      = decode_op(item.op);
    decoded.tx_byte  = item.tx_byte;
    decoded.send_ack = item.send_ack;
    decoded.data_in  = item.data_in;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/tsbm_back.sv =====
// Back end: bus waveform engine, one tick per beat, with a result queue.
module tsbm_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data,
  input  logic             tick_valid,
  input  tsbm_pkg::tick_t  tick,
  output logic             tick_take,
  output logic             empty,
  input  logic             pop,
  output tsbm_pkg::result_t result
);
  import tsbm_pkg::*;

  logic [7:0] phase_ticks;
  logic [4:0] phase_step, phase_step_next;
  cmd_t       current_command, current_command_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] tick_count, tick_count_next;
  logic       ack_choice, ack_choice_next;
  logic       ack_error, ack_error_next;
  logic       clock_reg, clock_reg_next;
  logic       drive_reg, drive_reg_next;
  logic       level_reg, level_reg_next;
  logic [7:0] rx_hold, rx_hold_next;

  result_t    res;
  result_t    oq [2];
  logic       owr_ptr;
  logic       ord_ptr;
  logic [1:0] ocount;
  logic       do_pop;

  logic [7:0] eff;
  logic       active;
  logic       samp;
  logic       ck_p, dr_p, lv_p;
  logic [4:0] k5;
  logic [2:0] k3;
  logic [4:0] step_inc;
  logic [4:0] total;
  logic [1:0] sp;

  assign do_pop    = pop && !empty;
  assign empty     = (ocount == 2'd0);
  assign result    = oq[ord_ptr];
  assign tick_take = tick_valid && ((ocount != 2'd2) || do_pop);

  always_comb begin
    eff                  = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
    phase_step_next      = phase_step;
    current_command_next = current_command;
    shift_byte_next      = shift_byte;
    tick_count_next      = tick_count;
    ack_choice_next      = ack_choice;
    ack_error_next       = ack_error;
    clock_reg_next       = clock_reg;
    drive_reg_next       = drive_reg;
    level_reg_next       = level_reg;
    rx_hold_next         = rx_hold;
    res                  = '0;
    samp                 = 1'b0;
    ck_p                 = 1'b0;
    dr_p                 = 1'b0;
    lv_p                 = 1'b1;
    k5                   = 5'd0;
    k3                   = 3'd0;
    sp                   = 2'b00;
    step_inc             = 5'd0;
    total                = BYTE_PHASES;

    active = (phase_step != IDLE_STEP);
    if (active && tick.cmd != CMD_NONE) begin
      res.rejected = 1'b1;
    end else if (!active && tick.cmd != CMD_NONE) begin
      current_command_next = tick.cmd;
      phase_step_next      = 5'd0;
      tick_count_next      = 8'd0;
      if (tick.cmd == CMD_WRITE) shift_byte_next = tick.tx_byte;
      if (tick.cmd == CMD_READ) begin
        shift_byte_next = 8'd0;
        ack_choice_next = tick.send_ack;
      end
      active = 1'b1;
    end

    res.sck_level  = clock_reg;
    res.data_drive = drive_reg;
    res.data_level = drive_reg ? level_reg : 1'b1;

    if (active) begin
      if (current_command_next == CMD_WAIT) begin
        clock_reg_next = 1'b0;
        drive_reg_next = 1'b0;
        level_reg_next = 1'b1;
        res.sck_level  = 1'b0;
        res.data_drive = 1'b0;
        res.data_level = 1'b1;
        if (!tick.data_in) begin
          res.done_res    = 1'b1;
          phase_step_next = IDLE_STEP;
        end
      end else begin
        // Line levels for the current phase
        if (current_command_next == CMD_START ||
            (current_command_next == CMD_CONN_RESET &&
             phase_step_next >= RESET_START_OFS)) begin
          k5 = (current_command_next == CMD_START) ? phase_step_next
                                                   : phase_step_next - RESET_START_OFS;
          k3 = (k5 > 5'd6) ? 3'd6 : k5[2:0];
          sp = start_phase(k3);
          ck_p = sp[1];
          dr_p = 1'b1;
          lv_p = sp[0];
        end else if (current_command_next == CMD_CONN_RESET) begin
          ck_p = phase_step_next[0];
          dr_p = 1'b1;
          lv_p = 1'b1;
        end else if (current_command_next == CMD_WRITE) begin
          ck_p = phase_step_next[0];
          if (phase_step_next < ACK_LOW_PHASE) begin
            dr_p = 1'b1;
            lv_p = shift_byte_next[3'd7 - phase_step_next[3:1]];
          end else begin
            dr_p = 1'b0;
            lv_p = 1'b1;
            samp = (phase_step_next == ACK_HIGH_PHASE);
          end
        end else begin
          ck_p = phase_step_next[0];
          if (phase_step_next < ACK_LOW_PHASE) begin
            dr_p = 1'b0;
            lv_p = 1'b1;
            samp = phase_step_next[0];
          end else begin
            dr_p = 1'b1;
            lv_p = !ack_choice_next;
          end
        end

        clock_reg_next = ck_p;
        drive_reg_next = dr_p;
        level_reg_next = lv_p;
        res.sck_level  = ck_p;
        res.data_drive = dr_p;
        res.data_level = dr_p ? lv_p : 1'b1;

        case (current_command_next)
          CMD_START:      total = START_PHASES;
          CMD_CONN_RESET: total = RESET_PHASES;
          default:        total = BYTE_PHASES;
        endcase

        // End of phase: sample, advance, finish on the last phase
        if ({1'b0, tick_count_next} + 9'd1 >= {1'b0, eff}) begin
          if (samp) begin
            if (current_command_next == CMD_WRITE) ack_error_next = tick.data_in;
            else shift_byte_next = {shift_byte_next[6:0], tick.data_in};
          end
          tick_count_next = 8'd0;
          step_inc        = phase_step_next + 5'd1;
          phase_step_next = step_inc;
          if (step_inc >= total) begin
            res.done_res    = 1'b1;
            phase_step_next = IDLE_STEP;
            clock_reg_next  = 1'b0;
            level_reg_next  = 1'b1;
            drive_reg_next  = (current_command_next == CMD_START ||
                               current_command_next == CMD_CONN_RESET);
            if (current_command_next == CMD_READ) rx_hold_next = shift_byte_next;
          end
        end else begin
          tick_count_next = tick_count_next + 8'd1;
        end
      end
    end

    res.busy_res = (phase_step_next != IDLE_STEP);
    res.rx_byte  = rx_hold_next;
    res.no_ack   = ack_error_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks     <= 8'd1;
      phase_step      <= IDLE_STEP;
      current_command <= CMD_NONE;
      shift_byte      <= 8'd0;
      tick_count      <= 8'd0;
      ack_choice      <= 1'b0;
      ack_error       <= 1'b0;
      clock_reg       <= 1'b0;
      drive_reg       <= 1'b0;
      level_reg       <= 1'b1;
      rx_hold         <= 8'd0;
    end else begin
      if (cfg_we) phase_ticks <= cfg_data;
      if (tick_take) begin
        phase_step      <= phase_step_next;
        current_command <= current_command_next;
        shift_byte      <= shift_byte_next;
        tick_count      <= tick_count_next;
        ack_choice      <= ack_choice_next;
        ack_error       <= ack_error_next;
        clock_reg       <= clock_reg_next;
        drive_reg       <= drive_reg_next;
        level_reg       <= level_reg_next;
        rx_hold         <= rx_hold_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      oq[owr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= 1'b0;
      ord_ptr <= 1'b0;
      ocount  <= 2'd0;
    end else begin
      if (tick_take) owr_ptr <= ~owr_ptr;
      if (do_pop) ord_ptr <= ~ord_ptr;
      case ({tick_take, do_pop})
        2'b10:   ocount <= ocount + 2'd1;
        2'b01:   ocount <= ocount - 2'd1;
        default: ocount <= ocount;
      endcase
    end
  end

endmodule

// ===== rtl/two_wire_sensor_bus_master_core.sv =====
// Top level of the two-wire sensor bus master: front decode queue feeding the waveform engine.
// Path: an accepted tick beat is registered in the front queue, then the engine registers its result
// into the result queue, which drives the result ports.
// Throughput: one tick beat per cycle while the result queue has room, set by the state update of the engine.
// Reset: synchronous rst empties both queues, idles the engine, clock low, data released,
// and sets the phase length to one tick.
module two_wire_sensor_bus_master_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  tsbm_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output tsbm_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data
);
  import tsbm_pkg::*;

  logic  tick_valid;
  logic  tick_take;
  tick_t tick;

  tsbm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .tick_valid (tick_valid),
    .tick       (tick),
    .tick_take  (tick_take)
  );

  tsbm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .tick_valid (tick_valid),
    .tick       (tick),
    .tick_take  (tick_take),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the two-wire sensor bus master: directed table, then random ticks.
module testbench;
  import tsbm_pkg::*;

  localparam logic [2:0] OP_UNDEF_A = 3'd6;
  localparam logic [2:0] OP_UNDEF_B = 3'd7;
  localparam int         N_OPENING  = 14;
  localparam int         LONG_HOLD  = 200;
  // Start condition waveform, bit k is phase k
  localparam logic [6:0] START_SCK  = 7'b0110110;
  localparam logic [6:0] START_LVL  = 7'b1100011;

  // sck, drive, level, busy, done, rx byte, no_ack, rejected
  localparam result_t R_NONE      = '0;
  localparam result_t R_IDLE      = {1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0};
  localparam result_t R_WAIT_DONE = {1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0};
  localparam result_t R_REFUSED   = {1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1};

  typedef struct packed {
    item_t   it;
    logic    run_out;
    logic    typed;
    result_t want;
  } opening_row_t;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  item_t      item;
  logic       empty;
  logic       pop;
  result_t    result;
  logic       cfg_we;
  logic [7:0] cfg_data;

  // Bus master model state
  logic [7:0] phase_len;
  logic [4:0] bus_step;
  cmd_t       bus_cmd;
  logic [7:0] bus_shift;
  logic [7:0] bus_count;
  logic [7:0] bus_rx;
  logic       bus_ack_low;
  logic       bus_no_ack;
  logic       bus_sck;
  logic       bus_drv;
  logic       bus_lvl;

  result_t      bus_results_due[$];
  opening_row_t opening_rows[N_OPENING];
  logic         typed_on;
  result_t      typed_want;
  item_t        fill_tick;

  int mismatches;
  int ticks_in;
  int results_out;
  int cmds_done;
  int cmds_refused;

  logic hold_req;
  logic hold_taken;
  int   hold_left;
  int   reader_cyc;

  two_wire_sensor_bus_master_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // One tick of the bus master: advance the model and return the lines it shows.
  function automatic result_t bus_tick(input item_t t);
    result_t    r;
    cmd_t       op;
    logic [7:0] eff;
    logic [4:0] k;
    logic [4:0] span;
    logic       busy;
    logic       smp;
    r    = R_NONE;
    op   = (t.op > CMD_WAIT) ? CMD_NONE : cmd_t'(t.op);
    eff  = (phase_len == 8'd0) ? 8'd1 : phase_len;
    busy = (bus_step != IDLE_STEP);
    smp  = 1'b0;
    if (busy && op != CMD_NONE) begin
      r.rejected = 1'b1;
    end else if (!busy && op != CMD_NONE) begin
      bus_cmd   = op;
      bus_step  = 5'd0;
      bus_count = 8'd0;
      if (op == CMD_WRITE) bus_shift = t.tx_byte;
      if (op == CMD_READ) begin
        bus_shift   = 8'd0;
        bus_ack_low = t.send_ack;
      end
      busy = 1'b1;
    end
    r.sck_level  = bus_sck;
    r.data_drive = bus_drv;
    r.data_level = bus_drv ? bus_lvl : 1'b1;
    if (busy) begin
      if (bus_cmd == CMD_WAIT) begin
        bus_sck      = 1'b0;
        bus_drv      = 1'b0;
        bus_lvl      = 1'b1;
        r.sck_level  = 1'b0;
        r.data_drive = 1'b0;
        r.data_level = 1'b1;
        if (!t.data_in) begin
          r.done_res = 1'b1;
          bus_step   = IDLE_STEP;
        end
      end else begin
        if (bus_cmd == CMD_START || (bus_cmd == CMD_CONN_RESET && bus_step >= RESET_START_OFS))
        begin
          k = (bus_cmd == CMD_START) ? bus_step : bus_step - RESET_START_OFS;
          if (k > 5'd6) k = 5'd6;
          bus_sck = START_SCK[k[2:0]];
          bus_drv = 1'b1;
          bus_lvl = START_LVL[k[2:0]];
        end else if (bus_cmd == CMD_CONN_RESET) begin
          bus_sck = bus_step[0];
          bus_drv = 1'b1;
          bus_lvl = 1'b1;
        end else if (bus_cmd == CMD_WRITE) begin
          bus_sck = bus_step[0];
          if (bus_step < ACK_LOW_PHASE) begin
            bus_drv = 1'b1;
            bus_lvl = bus_shift[3'd7 - bus_step[3:1]];
          end else begin
            bus_drv = 1'b0;
            bus_lvl = 1'b1;
            smp     = (bus_step == ACK_HIGH_PHASE);
          end
        end else begin
          bus_sck = bus_step[0];
          if (bus_step < ACK_LOW_PHASE) begin
            bus_drv = 1'b0;
            bus_lvl = 1'b1;
            smp     = bus_step[0];
          end else begin
            bus_drv = 1'b1;
            bus_lvl = ~bus_ack_low;
          end
        end
        r.sck_level  = bus_sck;
        r.data_drive = bus_drv;
        r.data_level = bus_drv ? bus_lvl : 1'b1;
        // A shortened phase length ends a phase that already ran past it
        if ({1'b0, bus_count} + 9'd1 >= {1'b0, eff}) begin
          if (smp) begin
            if (bus_cmd == CMD_WRITE) bus_no_ack = t.data_in;
            else bus_shift = {bus_shift[6:0], t.data_in};
          end
          bus_count = 8'd0;
          bus_step  = bus_step + 5'd1;
          span = (bus_cmd == CMD_START) ? START_PHASES :
                 (bus_cmd == CMD_CONN_RESET) ? RESET_PHASES : BYTE_PHASES;
          if (bus_step >= span) begin
            r.done_res = 1'b1;
            bus_step   = IDLE_STEP;
            bus_sck    = 1'b0;
            bus_lvl    = 1'b1;
            bus_drv    = (bus_cmd == CMD_START || bus_cmd == CMD_CONN_RESET);
            if (bus_cmd == CMD_READ) bus_rx = bus_shift;
          end
        end else begin
          bus_count = bus_count + 8'd1;
        end
      end
    end
    r.busy_res = (bus_step != IDLE_STEP);
    r.rx_byte  = bus_rx;
    r.no_ack   = bus_no_ack;
    return r;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("sck=%b drv=%b lvl=%b busy=%b done=%b rx=%h nack=%b rej=%b",
                     r.sck_level, r.data_drive, r.data_level, r.busy_res, r.done_res,
                     r.rx_byte, r.no_ack, r.rejected);
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      phase_len   = 8'd1;
      bus_step    = IDLE_STEP;
      bus_cmd     = CMD_NONE;
      bus_shift   = 8'd0;
      bus_count   = 8'd0;
      bus_rx      = 8'd0;
      bus_ack_low = 1'b0;
      bus_no_ack  = 1'b0;
      bus_sck     = 1'b0;
      bus_drv     = 1'b0;
      bus_lvl     = 1'b1;
      bus_results_due.delete();
    end else begin
      if (cfg_we) phase_len = cfg_data;
      if (push && !full) begin
        want = bus_tick(item);
        ticks_in++;
        if (want.done_res) cmds_done++;
        if (want.rejected) cmds_refused++;
        bus_results_due.push_back(typed_on ? typed_want : want);
      end
      if (pop && !empty) begin
        results_out++;
        if (bus_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d came with nothing predicted: %s", results_out, show(result));
        end else begin
          want = bus_results_due.pop_front();
          if (result.sck_level !== want.sck_level || result.data_drive !== want.data_drive ||
              result.data_level !== want.data_level || result.busy_res !== want.busy_res ||
              result.done_res !== want.done_res || result.rx_byte !== want.rx_byte ||
              result.no_ack !== want.no_ack || result.rejected !== want.rejected) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch: want %s got %s", results_out, show(want),
                       show(result));
          end
        end
      end
    end
  end

  // Call right after a falling edge; returns at the edge that takes the beat.
  task automatic send_beat(input item_t t, input logic typed, input result_t want);
    typed_on   = typed;
    typed_want = want;
    push <= 1'b1;
    item <= t;
    do @(posedge clk); while (full);
  endtask

  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk);
      push <= 1'b0;
    end
  endtask

  // Drain every outstanding beat, then write the phase length.
  task automatic set_phase_len(input logic [7:0] v);
    @(negedge clk);
    push <= 1'b0;
    while (bus_results_due.size() != 0) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int n, input logic gaps);
    int    sent;
    int    burst;
    int    roll;
    item_t t;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(24, 1);
      for (int b = 0; b < burst && sent < n; b++) begin
        @(negedge clk);
        t.tx_byte  = 8'($urandom);
        t.send_ack = 1'($urandom);
        t.data_in  = ($urandom_range(3, 0) != 0);
        roll       = $urandom_range(99, 0);
        // Mostly well-formed: start a command when idle, tick along while busy
        if (bus_step == IDLE_STEP) begin
          if (roll < 75) t.op = 3'($urandom_range(CMD_WAIT, CMD_START));
          else if (roll < 85) t.op = 3'($urandom_range(OP_UNDEF_B, OP_UNDEF_A));
          else t.op = CMD_NONE;
        end else begin
          if (roll < 4) t.op = 3'($urandom_range(CMD_WAIT, CMD_START));
          else if (roll < 6) t.op = 3'($urandom_range(OP_UNDEF_B, OP_UNDEF_A));
          else t.op = CMD_NONE;
        end
        send_beat(t, 1'b0, R_NONE);
        sent++;
      end
      if (gaps) pause($urandom_range(6, 0));
    end
  endtask

  initial begin
    rst          = 1'b1;
    push         = 1'b0;
    item         = '0;
    cfg_we       = 1'b0;
    cfg_data     = 8'd0;
    typed_on     = 1'b0;
    typed_want   = R_NONE;
    hold_req     = 1'b0;
    mismatches   = 0;
    ticks_in     = 0;
    results_out  = 0;
    cmds_done    = 0;
    cmds_refused = 0;

    // op, tx byte, send_ack, data_in | run until done, typed, expected
    opening_rows[0]  = {CMD_NONE,       8'h00, 1'b0, 1'b1, 1'b0, 1'b1, R_IDLE};
    opening_rows[1]  = {OP_UNDEF_A,     8'h5A, 1'b1, 1'b1, 1'b0, 1'b1, R_IDLE};
    opening_rows[2]  = {OP_UNDEF_B,     8'hA5, 1'b0, 1'b0, 1'b0, 1'b1, R_IDLE};
    opening_rows[3]  = {CMD_WAIT,       8'h00, 1'b0, 1'b0, 1'b0, 1'b1, R_WAIT_DONE};
    opening_rows[4]  = {CMD_WAIT,       8'h00, 1'b0, 1'b1, 1'b0, 1'b0, R_NONE};
    opening_rows[5]  = {CMD_WRITE,      8'hFF, 1'b0, 1'b1, 1'b0, 1'b1, R_REFUSED};
    opening_rows[6]  = {CMD_NONE,       8'h00, 1'b0, 1'b0, 1'b0, 1'b0, R_NONE};
    opening_rows[7]  = {CMD_START,      8'h00, 1'b0, 1'b1, 1'b1, 1'b0, R_NONE};
    opening_rows[8]  = {CMD_CONN_RESET, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, R_NONE};
    opening_rows[9]  = {CMD_WRITE,      8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, R_NONE};
    opening_rows[10] = {CMD_WRITE,      8'h00, 1'b0, 1'b0, 1'b1, 1'b0, R_NONE};
    opening_rows[11] = {CMD_READ,       8'h00, 1'b1, 1'b1, 1'b1, 1'b0, R_NONE};
    opening_rows[12] = {CMD_READ,       8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, R_NONE};
    opening_rows[13] = {CMD_NONE,       8'h00, 1'b0, 1'b1, 1'b0, 1'b1, R_IDLE};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_OPENING; i++) begin
      @(negedge clk);
      send_beat(opening_rows[i].it, opening_rows[i].typed, opening_rows[i].want);
      // Hold the data line steady and tick until the command finishes
      while (opening_rows[i].run_out) begin
        @(negedge clk);
        if (bus_step == IDLE_STEP) begin
          push <= 1'b0;
          break;
        end
        fill_tick.op       = CMD_NONE;
        fill_tick.tx_byte  = 8'($urandom);
        fill_tick.send_ack = 1'($urandom);
        fill_tick.data_in  = opening_rows[i].it.data_in;
        send_beat(fill_tick, 1'b0, R_NONE);
      end
    end

    set_phase_len(8'd1);
    hold_req = 1'b1;
    run_phase(300, 1'b1);
    set_phase_len(8'd0);
    run_phase(250, 1'b0);
    set_phase_len(8'd2);
    run_phase(300, 1'b1);
    set_phase_len(8'd255);
    run_phase(250, 1'b1);
    // Shorten the phase while a long command is still running
    set_phase_len(8'd3);
    run_phase(250, 1'b0);
    set_phase_len(8'($urandom_range(6, 4)));
    run_phase(250, 1'b1);
    set_phase_len(8'd1);
    run_phase(250, 1'b1);

    @(negedge clk);
    push <= 1'b0;
    while (bus_results_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("covered %0d ticks, %0d results, %0d commands finished, %0d refused while busy",
             ticks_in, results_out, cmds_done, cmds_refused);
    $display("phase lengths 0, 1, 2, 3, 255 and one random, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver: rotate through pop patterns, with one long hold-off to fill the block
  initial begin
    pop        = 1'b0;
    hold_taken = 1'b0;
    hold_left  = 0;
    reader_cyc = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (reader_cyc[7:6])
          2'd0:    pop <= 1'b1;
          2'd1:    pop <= 1'($urandom_range(1, 0));
          2'd2:    pop <= ($urandom_range(3, 0) == 0);
          default: pop <= (reader_cyc[2:0] != 3'd0);
        endcase
      end
      reader_cyc++;
    end
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule
